>>> src/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
`default_nettype none
package cau_pkg;

	localparam int PART_WIDTH = 32;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic signed [PART_WIDTH-1:0] a_re;
		logic signed [PART_WIDTH-1:0] a_im;
		logic signed [PART_WIDTH-1:0] b_re;
		logic signed [PART_WIDTH-1:0] b_im;
	} operands_t;

	typedef struct packed {
		logic signed [PART_WIDTH-1:0] res_re;
		logic signed [PART_WIDTH-1:0] res_im;
		status_t status;
	} result_t;

endpackage
`default_nettype wire

>>> src/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide in signed fixed point, fully pipelined.
// Depends on cau_pkg for the transaction structs, operation and status codes.
// Every transaction passes through the one-bit-per-stage restoring divider (2*PART_WIDTH +
// FRAC_BITS + 1 stages), whatever its operation. busy never rises: one transaction is
// accepted every cycle, and each result appears on result for one cycle with done high,
// in the order accepted.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire cau_pkg::operands_t operands,
	output logic                    done,
	output cau_pkg::result_t        result
);
	import cau_pkg::*;

	localparam int W = PART_WIDTH;
	localparam int PW = 2 * W;
	localparam int S = PW + 1;
	localparam int Q = S + FRAC_BITS;
	localparam int MW = Q + 1;
	localparam logic [S-1:0] HALF = (FRAC_BITS > 0) ? (S'(1) << (FRAC_BITS - 1)) : '0;
	localparam logic [MW-1:0] MAX_POS = MW'((65'(1) << (W - 1)) - 65'(1));
	localparam logic [MW-1:0] MAX_NEG = MW'(65'(1) << (W - 1));
	localparam logic signed [W-1:0] SAT_MAX = W'(MAX_POS);
	localparam logic signed [W-1:0] SAT_MIN = W'(MAX_NEG);

	logic v_s1;
	operands_t in_s1;

	logic v_s2, zero_s2;
	kind_t kind_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_bb_s2, p_bi_s2;
	logic signed [W:0] as_re_s2, as_im_s2;

	logic v_s3, zero_s3;
	kind_t kind_s3;
	logic signed [S-1:0] sre_s3, sim_s3;
	logic [PW-1:0] d_s3;

	logic v_s4, zero_s4, neg_re_s4, neg_im_s4;
	kind_t kind_s4;
	logic [S-1:0] mag_re_s4, mag_im_s4;
	logic [PW-1:0] d_s4;

	logic v_sd [0:Q];
	logic zero_sd [0:Q];
	logic neg_re_sd [0:Q];
	logic neg_im_sd [0:Q];
	kind_t kind_sd [0:Q];
	logic [PW-1:0] d_sd [0:Q];
	logic [PW-1:0] rem_re_sd [0:Q];
	logic [PW-1:0] rem_im_sd [0:Q];
	logic [Q-1:0] nq_re_sd [0:Q];
	logic [Q-1:0] nq_im_sd [0:Q];
	logic [S-1:0] smag_re_sd [0:Q];
	logic [S-1:0] smag_im_sd [0:Q];

	logic v_s5, zero_s5, neg_re_s5, neg_im_s5;
	logic [MW-1:0] mag_re_s5, mag_im_s5;

	logic v_s6;
	result_t res_s6;

	logic signed [S-1:0] sre_c, sim_c;
	logic [S-1:0] abs_re_c, abs_im_c;
	logic [MW-1:0] fin_re_c, fin_im_c;
	logic rnd_re_c, rnd_im_c;
	logic signed [W-1:0] sat_re_c, sat_im_c;
	logic ovf_re_c, ovf_im_c;

	assign busy = 1'b0;

	always_comb begin
		unique case (kind_s2)
			OP_ADD, OP_SUB: begin
				sre_c = S'(as_re_s2);
				sim_c = S'(as_im_s2);
			end
			OP_MUL: begin
				sre_c = S'(p_rr_s2) - S'(p_ii_s2);
				sim_c = S'(p_ir_s2) + S'(p_ri_s2);
			end
			default: begin
				sre_c = S'(p_rr_s2) + S'(p_ii_s2);
				sim_c = S'(p_ir_s2) - S'(p_ri_s2);
			end
		endcase
		abs_re_c = sre_s3[S-1] ? -sre_s3 : sre_s3;
		abs_im_c = sim_s3[S-1] ? -sim_s3 : sim_s3;
	end

	always_comb begin
		rnd_re_c = {rem_re_sd[Q], 1'b0} >= {1'b0, d_sd[Q]};
		rnd_im_c = {rem_im_sd[Q], 1'b0} >= {1'b0, d_sd[Q]};
		if (kind_sd[Q] == OP_DIV) begin
			fin_re_c = MW'(nq_re_sd[Q]) + MW'(rnd_re_c);
			fin_im_c = MW'(nq_im_sd[Q]) + MW'(rnd_im_c);
		end else begin
			fin_re_c = MW'(smag_re_sd[Q]);
			fin_im_c = MW'(smag_im_sd[Q]);
		end
	end

	always_comb begin
		if (neg_re_s5) begin
			ovf_re_c = mag_re_s5 > MAX_NEG;
			sat_re_c = ovf_re_c ? SAT_MIN : W'(-mag_re_s5);
		end else begin
			ovf_re_c = mag_re_s5 > MAX_POS;
			sat_re_c = ovf_re_c ? SAT_MAX : W'(mag_re_s5);
		end
		if (neg_im_s5) begin
			ovf_im_c = mag_im_s5 > MAX_NEG;
			sat_im_c = ovf_im_c ? SAT_MIN : W'(-mag_im_s5);
		end else begin
			ovf_im_c = mag_im_s5 > MAX_POS;
			sat_im_c = ovf_im_c ? SAT_MAX : W'(mag_im_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k <= Q; k++) v_sd[k] <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd[0] <= v_s4;
			for (int k = 1; k <= Q; k++) v_sd[k] <= v_sd[k-1];
			v_s5 <= v_sd[Q];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic [PW:0] t_re, t_im;
		logic ge_re, ge_im;
		in_s1 <= operands;

		kind_s2 <= in_s1.kind;
		zero_s2 <= (in_s1.b_re == '0) && (in_s1.b_im == '0);
		p_rr_s2 <= PW'(in_s1.a_re) * PW'(in_s1.b_re);
		p_ii_s2 <= PW'(in_s1.a_im) * PW'(in_s1.b_im);
		p_ir_s2 <= PW'(in_s1.a_im) * PW'(in_s1.b_re);
		p_ri_s2 <= PW'(in_s1.a_re) * PW'(in_s1.b_im);
		p_bb_s2 <= PW'(in_s1.b_re) * PW'(in_s1.b_re);
		p_bi_s2 <= PW'(in_s1.b_im) * PW'(in_s1.b_im);
		if (in_s1.kind == OP_SUB) begin
			as_re_s2 <= (W+1)'(in_s1.a_re) - (W+1)'(in_s1.b_re);
			as_im_s2 <= (W+1)'(in_s1.a_im) - (W+1)'(in_s1.b_im);
		end else begin
			as_re_s2 <= (W+1)'(in_s1.a_re) + (W+1)'(in_s1.b_re);
			as_im_s2 <= (W+1)'(in_s1.a_im) + (W+1)'(in_s1.b_im);
		end

		kind_s3 <= kind_s2;
		zero_s3 <= zero_s2;
		sre_s3 <= sre_c;
		sim_s3 <= sim_c;
		d_s3 <= $unsigned(p_bb_s2) + $unsigned(p_bi_s2);

		kind_s4 <= kind_s3;
		zero_s4 <= zero_s3;
		d_s4 <= d_s3;
		neg_re_s4 <= sre_s3[S-1];
		neg_im_s4 <= sim_s3[S-1];
		mag_re_s4 <= abs_re_c;
		mag_im_s4 <= abs_im_c;

		kind_sd[0] <= kind_s4;
		zero_sd[0] <= zero_s4;
		neg_re_sd[0] <= neg_re_s4;
		neg_im_sd[0] <= neg_im_s4;
		d_sd[0] <= d_s4;
		rem_re_sd[0] <= '0;
		rem_im_sd[0] <= '0;
		nq_re_sd[0] <= Q'(mag_re_s4) << FRAC_BITS;
		nq_im_sd[0] <= Q'(mag_im_s4) << FRAC_BITS;
		if (kind_s4 == OP_MUL) begin
			smag_re_sd[0] <= (mag_re_s4 + HALF) >> FRAC_BITS;
			smag_im_sd[0] <= (mag_im_s4 + HALF) >> FRAC_BITS;
		end else begin
			smag_re_sd[0] <= mag_re_s4;
			smag_im_sd[0] <= mag_im_s4;
		end

		for (int k = 1; k <= Q; k++) begin
			t_re = {rem_re_sd[k-1], nq_re_sd[k-1][Q-1]};
			t_im = {rem_im_sd[k-1], nq_im_sd[k-1][Q-1]};
			ge_re = t_re >= {1'b0, d_sd[k-1]};
			ge_im = t_im >= {1'b0, d_sd[k-1]};
			rem_re_sd[k] <= ge_re ? PW'(t_re - {1'b0, d_sd[k-1]}) : PW'(t_re);
			rem_im_sd[k] <= ge_im ? PW'(t_im - {1'b0, d_sd[k-1]}) : PW'(t_im);
			nq_re_sd[k] <= {nq_re_sd[k-1][Q-2:0], ge_re};
			nq_im_sd[k] <= {nq_im_sd[k-1][Q-2:0], ge_im};
			kind_sd[k] <= kind_sd[k-1];
			zero_sd[k] <= zero_sd[k-1];
			neg_re_sd[k] <= neg_re_sd[k-1];
			neg_im_sd[k] <= neg_im_sd[k-1];
			d_sd[k] <= d_sd[k-1];
			smag_re_sd[k] <= smag_re_sd[k-1];
			smag_im_sd[k] <= smag_im_sd[k-1];
		end

		zero_s5 <= zero_sd[Q] && (kind_sd[Q] == OP_DIV);
		neg_re_s5 <= neg_re_sd[Q];
		neg_im_s5 <= neg_im_sd[Q];
		mag_re_s5 <= fin_re_c;
		mag_im_s5 <= fin_im_c;

		if (zero_s5) begin
			res_s6.res_re <= '0;
			res_s6.res_im <= '0;
			res_s6.status <= ST_DIV0;
		end else begin
			res_s6.res_re <= sat_re_c;
			res_s6.res_im <= sat_im_c;
			res_s6.status <= (ovf_re_c || ovf_im_c) ? ST_OVF : ST_OK;
		end
	end

	assign done = v_s6;
	assign result = res_s6;

endmodule
`default_nettype wire
